// ----- src/pps_pkg.sv -----
// pps_pkg: widths, limits, codes, controller states and command/status structs
// for the pwm period divider solver; no dependencies
package pps_pkg;

   localparam int DIVIDER_LIMIT = 256;
   localparam int MAX_TOP       = 65535;
   localparam int DUTY_FULL     = 10000;

   localparam int CLK_W   = 32;
   localparam int FREQ_W  = 31;
   localparam int DUTY_W  = 14;
   localparam int TOP_W   = 16;
   localparam int DIV_W   = 9;
   localparam int STAT_W  = 2;
   localparam int CSR_IW  = 1;
   localparam int RATE_W  = FREQ_W + 1;
   localparam int DSTEP_W = $clog2(DIVIDER_LIMIT);
   localparam int P_W     = RATE_W + DSTEP_W;
   localparam int MUL_W   = $clog2(MAX_TOP + 3);
   localparam int INC_W   = RATE_W + MUL_W;
   localparam int M_W     = INC_W + DSTEP_W;
   localparam int PROD_W  = TOP_W + DUTY_W;
   localparam int CNT_W   = $clog2(CLK_W);

   // reciprocal of the full duty, ceil(2^44 / 10000); exact floor for products below 2^30
   localparam int RCP_SHIFT = 44;
   localparam int RCP_W     = 31;
   localparam int SCL_W     = PROD_W + RCP_W;
   localparam logic [RCP_W-1:0] DUTY_RECIP =
      RCP_W'(((64'd1 << RCP_SHIFT) / 64'(DUTY_FULL)) + 64'd1);

   localparam logic [CLK_W-1:0] CLOCK_RESET = CLK_W'(125000000);

   localparam logic [CSR_IW-1:0] CSR_CLOCK_HZ = CSR_IW'(0);
   localparam logic [CSR_IW-1:0] CSR_PHASE    = CSR_IW'(1);

   localparam logic [STAT_W-1:0] STATUS_OK    = STAT_W'(0);
   localparam logic [STAT_W-1:0] STATUS_ZERO  = STAT_W'(1);
   localparam logic [STAT_W-1:0] STATUS_NOFIT = STAT_W'(2);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_QDIV,
      ST_MUL,
      ST_SCALE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic start_q;
      logic take_q;
      logic set_zero;
      logic set_fallback;
      logic mul;
      logic take_c;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic zero;
      logic found;
      logic fits;
      logic last;
      logic div_done;
      logic out_busy;
   } stat_type;

endpackage

// ----- src/pps_if.sv -----
// pps_req_if / pps_rsp_if: valid/ready channels for request and result transactions
// depends on pps_pkg
interface pps_req_if import pps_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [FREQ_W-1:0] freq_hz;
   logic [DUTY_W-1:0] duty_hundredths;

   modport source (output valid, output freq_hz, output duty_hundredths, input ready);
   modport sink   (input valid, input freq_hz, input duty_hundredths, output ready);
endinterface

interface pps_rsp_if import pps_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TOP_W-1:0]  wrap_top;
   logic [DIV_W-1:0]  clock_divider;
   logic [TOP_W-1:0]  compare_level;
   logic [STAT_W-1:0] status;

   modport source (output valid, output wrap_top, output clock_divider,
                   output compare_level, output status, input ready);
   modport sink   (input valid, input wrap_top, input clock_divider,
                   input compare_level, input status, output ready);
endinterface

// ----- src/pwm_period_divider_solver_top.sv -----
// pwm_period_divider_solver_top: picks clock divider, wrap value and compare level
// a request runs the divider search, then the top division, duty multiply and compare
// scaling; zero frequency goes straight to the result, fallback skips the division
// throughput: one transaction at a time, next request taken the cycle after the result
// loads; set by the divider search loop and the 32-step top division
// reset: registers go to 125 MHz and phase-correct mode, sequencer idle, no result held
module pwm_period_divider_solver_top import pps_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [CLK_W-1:0]  csr_wdata,
   pps_req_if.sink           req_chan,
   pps_rsp_if.source         rsp_chan
);

   // command and status between sequencer and datapath
   cmd_type  cmd;
   stat_type stat;

   // sequencer: search one divider per cycle, then the top division and compare scaling
   pps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath: config, accumulators, top divider, output register
   // the output register lets a new request in while the last result waits
   pps_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_freq_hz         (req_chan.freq_hz),
      .req_duty_hundredths (req_chan.duty_hundredths),
      .cmd                 (cmd),
      .stat                (stat),
      .rsp_ready           (rsp_chan.ready),
      .rsp_valid           (rsp_chan.valid),
      .rsp_wrap_top        (rsp_chan.wrap_top),
      .rsp_clock_divider   (rsp_chan.clock_divider),
      .rsp_compare_level   (rsp_chan.compare_level),
      .rsp_status          (rsp_chan.status)
   );

endmodule

// ----- src/pps_div.sv -----
// pps_div: restoring divider, one quotient bit per cycle
// depends on pps_pkg
module pps_div import pps_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [CLK_W-1:0] dividend,
   input  logic [P_W-1:0]   divisor,
   output logic             done,
   output logic [CLK_W-1:0] quotient
);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CLK_W-1:0] quo_ff, quo_in;
   logic [P_W-1:0]   rem_ff, rem_in;
   logic [P_W-1:0]   den_ff, den_in;
   logic [P_W:0]     shifted;

   assign shifted = {rem_ff, quo_ff[CLK_W-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = P_W'(shifted - {1'b0, den_ff});
            quo_in = {quo_ff[CLK_W-2:0], 1'b1};
         end else begin
            rem_in = P_W'(shifted);
            quo_in = {quo_ff[CLK_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(CLK_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- src/pps_ctrl.sv -----
// pps_ctrl: sequencer for search, division, multiply, scaling and result hand-off
// depends on pps_pkg
module pps_ctrl import pps_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (stat.zero) begin
               cmd.set_zero = 1'b1;
               state_in     = ST_DONE;
            end else if (stat.found && stat.fits) begin
               cmd.start_q = 1'b1;
               state_in    = ST_QDIV;
            end else if (stat.found || stat.last) begin
               cmd.set_fallback = 1'b1;
               state_in         = ST_MUL;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_QDIV: begin
            if (stat.div_done) begin
               cmd.take_q = 1'b1;
               state_in   = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.take_c = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (!stat.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- src/pps_dp.sv -----
// pps_dp: config registers, divider search accumulators, top divider,
// duty multiply and scaling, output register; depends on pps_pkg and pps_div
module pps_dp import pps_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [CLK_W-1:0]  csr_wdata,
   input  logic [FREQ_W-1:0] req_freq_hz,
   input  logic [DUTY_W-1:0] req_duty_hundredths,
   input  cmd_type           cmd,
   output stat_type          stat,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic [TOP_W-1:0]  rsp_wrap_top,
   output logic [DIV_W-1:0]  rsp_clock_divider,
   output logic [TOP_W-1:0]  rsp_compare_level,
   output logic [STAT_W-1:0] rsp_status
);

   logic [CLK_W-1:0]  clock_hz_ff;
   logic              phase_ff;
   logic [RATE_W-1:0] rate_ff;
   logic              zero_ff;
   logic [DUTY_W-1:0] duty_ff;
   logic [P_W-1:0]    p_ff;
   logic [M_W-1:0]    m_ff;
   logic [INC_W-1:0]  inc_ff;
   logic [DIV_W-1:0]  d_ff;
   logic [TOP_W-1:0]  top_ff;
   logic [DIV_W-1:0]  cdiv_ff;
   logic [STAT_W-1:0] status_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [TOP_W-1:0]  level_ff;
   logic              rsp_valid_ff;
   logic [TOP_W-1:0]  rsp_top_ff;
   logic [DIV_W-1:0]  rsp_div_ff;
   logic [TOP_W-1:0]  rsp_level_ff;
   logic [STAT_W-1:0] rsp_status_ff;

   logic [RATE_W-1:0] rate_in;
   logic [INC_W-1:0]  inc_in;
   logic [DUTY_W-1:0] duty_in;
   logic [SCL_W-1:0]  scaled;
   logic              div_done;
   logic [CLK_W-1:0]  div_quo;

   // wrap rate doubles in dual-slope mode
   assign rate_in = phase_ff ? {req_freq_hz, 1'b0} : {1'b0, req_freq_hz};
   // per-step increment of the q <= MAX_TOP+1 bound, (MAX_TOP+2)*rate
   assign inc_in  = {{MUL_W{1'b0}}, rate_in}
                  * {{RATE_W{1'b0}}, MUL_W'(MAX_TOP + 2)};
   assign duty_in = (req_duty_hundredths > DUTY_W'(DUTY_FULL))
                  ? DUTY_W'(DUTY_FULL) : req_duty_hundredths;

   // divide by the full duty through the reciprocal
   assign scaled = SCL_W'(prod_ff) * SCL_W'(DUTY_RECIP);

   pps_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.start_q),
      .dividend (clock_hz_ff),
      .divisor  (p_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      stat.zero     = zero_ff;
      stat.found    = M_W'(clock_hz_ff) < m_ff;
      stat.fits     = P_W'(clock_hz_ff) >= p_ff;
      stat.last     = d_ff == DIV_W'(DIVIDER_LIMIT);
      stat.div_done = div_done;
      stat.out_busy = rsp_valid_ff & ~rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_hz_ff <= CLOCK_RESET;
         phase_ff    <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CLOCK_HZ: clock_hz_ff <= csr_wdata;
            CSR_PHASE:    phase_ff    <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rate_ff <= rate_in;
         zero_ff <= req_freq_hz == '0;
         duty_ff <= duty_in;
         p_ff    <= P_W'(rate_in);
         m_ff    <= M_W'(inc_in);
         inc_ff  <= inc_in;
         d_ff    <= DIV_W'(1);
      end else if (cmd.step) begin
         p_ff <= p_ff + P_W'(rate_ff);
         m_ff <= m_ff + M_W'(inc_ff);
         d_ff <= d_ff + DIV_W'(1);
      end
      if (cmd.set_zero) begin
         top_ff    <= '0;
         cdiv_ff   <= DIV_W'(1);
         status_ff <= STATUS_ZERO;
         level_ff  <= '0;
      end else if (cmd.set_fallback) begin
         top_ff    <= TOP_W'(MAX_TOP);
         cdiv_ff   <= DIV_W'(DIVIDER_LIMIT);
         status_ff <= STATUS_NOFIT;
      end else if (cmd.take_q) begin
         top_ff    <= TOP_W'(div_quo - CLK_W'(1));
         cdiv_ff   <= d_ff;
         status_ff <= STATUS_OK;
      end
      if (cmd.mul) begin
         prod_ff <= PROD_W'(top_ff) * PROD_W'(duty_ff);
      end
      if (cmd.take_c) begin
         level_ff <= scaled[RCP_SHIFT +: TOP_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         rsp_top_ff    <= top_ff;
         rsp_div_ff    <= cdiv_ff;
         rsp_level_ff  <= level_ff;
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_wrap_top      = rsp_top_ff;
   assign rsp_clock_divider = rsp_div_ff;
   assign rsp_compare_level = rsp_level_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

// ----- src/pps_checker.sv -----
// pps_checker: port-level assertions on the solver, bound to the top level
// depends on pps_pkg
module pps_checker import pps_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [TOP_W-1:0]  rsp_wrap_top,
   input logic [DIV_W-1:0]  rsp_clock_divider,
   input logic [TOP_W-1:0]  rsp_compare_level,
   input logic [STAT_W-1:0] rsp_status
);

   // result held until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // one request at a time
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // compare level never passes the wrap value
   a_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_compare_level <= rsp_wrap_top)
      else $error("compare level above wrap");

   // zero frequency gives fixed fields
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_ZERO |->
         rsp_wrap_top == '0 && rsp_clock_divider == DIV_W'(1) && rsp_compare_level == '0)
      else $error("zero frequency fields wrong");

   // fallback gives largest divider and wrap
   a_fallback: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_NOFIT |->
         rsp_wrap_top == TOP_W'(MAX_TOP) && rsp_clock_divider == DIV_W'(DIVIDER_LIMIT))
      else $error("fallback fields wrong");

endmodule

bind pwm_period_divider_solver_top pps_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_wrap_top      (rsp_chan.wrap_top),
   .rsp_clock_divider (rsp_chan.clock_divider),
   .rsp_compare_level (rsp_chan.compare_level),
   .rsp_status        (rsp_chan.status)
);
